@@ rtl/core/btmx_pkg.sv @@
// Shared constants and types for the binary trie maximum XOR block.
package btmx_pkg;

  // Trie geometry.
  localparam int NODE_POOL = 8192;
  localparam int KEY_BITS  = 32;
  localparam int PTR_W     = $clog2(NODE_POOL);
  localparam int CNT_W     = PTR_W + 1;
  localparam int LVL_W     = $clog2(KEY_BITS);

  typedef logic [PTR_W-1:0] ptr_t;

  // One trie node: two child indices, zero meaning no child.
  typedef struct packed {
    ptr_t lo;
    ptr_t hi;
  } node_t;

  // Write port of the node store.
  typedef struct packed {
    logic  en;
    ptr_t  addr;
    node_t data;
  } mem_wr_t;

endpackage

@@ rtl/core/binary_trie_max_xor_top.sv @@
// Top level of the binary trie maximum XOR block.
//
// Usage: an item transfer happens on a rising edge with start high and busy
// low; value and first_of_set are sampled then. With first_of_set high the
// trie and the running maximum are cleared before the value is handled.
// The value is inserted into the trie (a walk of existing nodes, then the
// link of the first fresh node and the writes of the fresh nodes), then the
// trie is walked again for the largest XOR. Each walk visits one node per
// cycle, set by the single read port of the node store. When the item is
// through, done is high for a single cycle with busy low, so a new item
// can transfer there.
// The result (best_xor, running_max, pool_full) is shown for exactly one
// cycle with done high; the receiver cannot stall it and must take it then.
// pool_full marks an item whose insert was skipped for lack of free nodes.
// Reset (rst, synchronous) empties the trie and clears the running maximum;
// the root lives in registers, so no clearing pass over the store is needed.
module binary_trie_max_xor_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] value,
  input  logic        first_of_set,
  output logic        done,
  output logic [31:0] best_xor,
  output logic [31:0] running_max,
  output logic        pool_full
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_INS   = 4'b0010,
    ST_ALLOC = 4'b0100,
    ST_QRY   = 4'b1000
  } state_t;

  localparam int SUM_W = btmx_pkg::CNT_W + 1;

  state_t                       state, state_next;
  logic [31:0]                  key;
  logic [btmx_pkg::LVL_W-1:0]   lvl, lvl_next;
  btmx_pkg::ptr_t               node, node_next;
  btmx_pkg::ptr_t               wptr, wptr_next;
  logic [31:0]                  acc, acc_next;
  btmx_pkg::node_t              root, root_next;
  logic [btmx_pkg::CNT_W-1:0]   nodes_used, nodes_used_next;
  logic [31:0]                  best;
  logic                         ins_full, ins_full_next;
  logic                         finish;
  logic [31:0]                  result_x;
  logic                         accept;

  btmx_pkg::node_t              rd_data;
  btmx_pkg::node_t              cur_ent;
  btmx_pkg::node_t              upd_ent;
  btmx_pkg::node_t              fresh_ent;
  btmx_pkg::mem_wr_t            wr;
  logic                         bit_b;
  logic                         next_b;
  btmx_pkg::ptr_t               same_c;
  btmx_pkg::ptr_t               other_c;
  logic [btmx_pkg::LVL_W:0]     needed;
  logic [SUM_W-1:0]             need_sum;
  logic                         no_room;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  btmx_node_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (node_next),
    .rd_data (rd_data)
  );

  // Current node contents: the root sits in registers, the rest in memory.
  always_comb begin
    cur_ent  = (node == '0) ? root : rd_data;
    bit_b    = key[lvl];
    same_c   = bit_b ? cur_ent.hi : cur_ent.lo;
    other_c  = bit_b ? cur_ent.lo : cur_ent.hi;
    needed   = {1'b0, lvl} + 1'b1;
    need_sum = SUM_W'(nodes_used) + SUM_W'(needed);
    no_room  = need_sum > SUM_W'(btmx_pkg::NODE_POOL);
    next_b   = (lvl != '0) ? key[lvl - 1'b1] : 1'b0;
  end

  // Parent entry with the new child linked in, and the entry of a fresh node.
  always_comb begin
    upd_ent = cur_ent;
    if (bit_b) begin
      upd_ent.hi = nodes_used[btmx_pkg::PTR_W-1:0];
    end else begin
      upd_ent.lo = nodes_used[btmx_pkg::PTR_W-1:0];
    end
    fresh_ent = '0;
    if (lvl != '0) begin
      if (next_b) begin
        fresh_ent.hi = wptr + 1'b1;
      end else begin
        fresh_ent.lo = wptr + 1'b1;
      end
    end
  end

  // Sequencer for the insert walk, node allocation and query walk.
  always_comb begin
    state_next      = state;
    lvl_next        = lvl;
    node_next       = node;
    wptr_next       = wptr;
    acc_next        = acc;
    root_next       = root;
    nodes_used_next = nodes_used;
    ins_full_next   = ins_full;
    finish          = 1'b0;
    result_x        = acc;
    wr              = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next    = ST_INS;
          lvl_next      = btmx_pkg::LVL_W'(btmx_pkg::KEY_BITS - 1);
          node_next     = '0;
          ins_full_next = 1'b0;
          if (first_of_set) begin
            root_next       = '0;
            nodes_used_next = btmx_pkg::CNT_W'(1);
          end
        end
      end
      ST_INS: begin
        if (same_c != '0) begin
          node_next = same_c;
          if (lvl == '0) begin
            state_next = ST_QRY;
            node_next  = '0;
            lvl_next   = btmx_pkg::LVL_W'(btmx_pkg::KEY_BITS - 1);
            acc_next   = '0;
          end else begin
            lvl_next = lvl - 1'b1;
          end
        end else if (no_room) begin
          ins_full_next = 1'b1;
          state_next    = ST_QRY;
          node_next     = '0;
          lvl_next      = btmx_pkg::LVL_W'(btmx_pkg::KEY_BITS - 1);
          acc_next      = '0;
        end else begin
          // Link the first fresh node under the node where the path ends.
          if (node == '0) begin
            root_next = upd_ent;
          end else begin
            wr.en   = 1'b1;
            wr.addr = node;
            wr.data = upd_ent;
          end
          wptr_next       = nodes_used[btmx_pkg::PTR_W-1:0];
          nodes_used_next = nodes_used + btmx_pkg::CNT_W'(needed);
          state_next      = ST_ALLOC;
        end
      end
      ST_ALLOC: begin
        // Each fresh node points at the next fresh node, the last is a leaf.
        wr.en     = 1'b1;
        wr.addr   = wptr;
        wr.data   = fresh_ent;
        wptr_next = wptr + 1'b1;
        if (lvl == '0) begin
          state_next = ST_QRY;
          node_next  = '0;
          lvl_next   = btmx_pkg::LVL_W'(btmx_pkg::KEY_BITS - 1);
          acc_next   = '0;
        end else begin
          lvl_next = lvl - 1'b1;
        end
      end
      ST_QRY: begin
        if (other_c != '0) begin
          node_next = other_c;
          acc_next  = acc | (32'd1 << lvl);
        end else if (same_c != '0) begin
          node_next = same_c;
        end
        if ((other_c == '0) && (same_c == '0)) begin
          finish     = 1'b1;
          result_x   = '0;
          state_next = ST_IDLE;
        end else if (lvl == '0) begin
          finish     = 1'b1;
          result_x   = acc_next;
          state_next = ST_IDLE;
        end else begin
          lvl_next = lvl - 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control and trie bookkeeping registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      root       <= '0;
      nodes_used <= btmx_pkg::CNT_W'(1);
      best       <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      root       <= root_next;
      nodes_used <= nodes_used_next;
      done       <= finish;
      if (accept && first_of_set) begin
        best <= '0;
      end else if (finish && (result_x > best)) begin
        best <= result_x;
      end
    end
  end

  // Working registers and the result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      key <= value;
    end
    lvl      <= lvl_next;
    node     <= node_next;
    wptr     <= wptr_next;
    acc      <= acc_next;
    ins_full <= ins_full_next;
    if (finish) begin
      best_xor    <= result_x;
      running_max <= (result_x > best) ? result_x : best;
      pool_full   <= ins_full;
    end
  end

  // The allocation count never passes the size of the node store.
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    nodes_used <= btmx_pkg::CNT_W'(btmx_pkg::NODE_POOL))
    else $error("nodes_used exceeds the node pool");

  // The root lives in registers and is never written into the store.
  a_no_root_write: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (wr.addr != '0))
    else $error("node store write aimed at the root entry");

  // A delivered result never exceeds the running maximum delivered with it.
  a_max_order: assert property (@(posedge clk) disable iff (rst)
    done |-> (running_max >= best_xor))
    else $error("running_max below best_xor");

  // An accepted item keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy && !done))
    else $error("block not busy after an item transfer");

  // A skipped insert leaves the allocation count unchanged.
  a_full_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INS) && (same_c == '0) && no_room |=> $stable(nodes_used))
    else $error("nodes_used changed on a skipped insert");

endmodule

@@ rtl/core/btmx_node_mem.sv @@
// Node store: single-port-write, registered-read memory of trie nodes.
module btmx_node_mem (
  input  logic              clk,
  input  btmx_pkg::mem_wr_t wr,
  input  btmx_pkg::ptr_t    rd_addr,
  output btmx_pkg::node_t   rd_data
);

  btmx_pkg::node_t mem [btmx_pkg::NODE_POOL];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ tb/sv/binary_trie_max_xor_checker.sv @@
// Checker that predicts and compares every result of the binary trie maximum XOR block.
module binary_trie_max_xor_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] value,
  input  logic        first_of_set,
  input  logic        done,
  input  logic [31:0] best_xor,
  input  logic [31:0] running_max,
  input  logic        pool_full,
  output int          mismatches,
  output int          outstanding,
  output int          refused
);

  // One predicted result, in the order its item was transferred.
  typedef struct packed {
    logic [31:0] xr;
    logic [31:0] peak;
    logic        full;
  } answer_t;

  answer_t answers_due[$];

  // Private copy of the trie: child indices per node, zero meaning no child.
  btmx_pkg::ptr_t kid_lo [btmx_pkg::NODE_POOL];
  btmx_pkg::ptr_t kid_hi [btmx_pkg::NODE_POOL];
  int unsigned    nodes_taken;
  logic [31:0]    peak_xor;

  // Empty the trie down to a childless root and drop the running maximum.
  task automatic trie_clear();
    kid_lo[0]   = '0;
    kid_hi[0]   = '0;
    nodes_taken = 1;
    peak_xor    = '0;
  endtask

  function automatic btmx_pkg::ptr_t child_of(btmx_pkg::ptr_t node, logic b);
    return b ? kid_hi[node] : kid_lo[node];
  endfunction

  // Follow the existing path of the key, then add the missing tail if it fits.
  task automatic trie_insert(input logic [31:0] key, output logic skipped);
    btmx_pkg::ptr_t node;
    btmx_pkg::ptr_t c;
    btmx_pkg::ptr_t fresh;
    int             lvl;
    int unsigned    needed;
    logic           walking;
    node    = '0;
    lvl     = btmx_pkg::KEY_BITS - 1;
    walking = 1'b1;
    while (walking && lvl >= 0) begin
      c = child_of(node, key[lvl]);
      if (c == '0) begin
        walking = 1'b0;
      end else begin
        node = c;
        lvl--;
      end
    end
    needed  = lvl + 1;
    skipped = 1'b0;
    if (needed != 0) begin
      if (nodes_taken > btmx_pkg::NODE_POOL ||
          needed > btmx_pkg::NODE_POOL - nodes_taken) begin
        skipped = 1'b1;
      end else begin
        while (lvl >= 0) begin
          fresh = btmx_pkg::ptr_t'(nodes_taken);
          nodes_taken++;
          kid_lo[fresh] = '0;
          kid_hi[fresh] = '0;
          if (key[lvl]) kid_hi[node] = fresh;
          else kid_lo[node] = fresh;
          node = fresh;
          lvl--;
        end
      end
    end
  endtask

  // Greedy walk that takes the opposite bit wherever the trie offers it.
  function automatic logic [31:0] trie_best_xor(logic [31:0] key);
    btmx_pkg::ptr_t node;
    btmx_pkg::ptr_t other;
    btmx_pkg::ptr_t same;
    logic [31:0]    acc;
    logic           dead;
    node = '0;
    acc  = '0;
    dead = 1'b0;
    for (int lvl = btmx_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
      if (!dead) begin
        other = child_of(node, ~key[lvl]);
        same  = child_of(node, key[lvl]);
        if (other != '0) begin
          node     = other;
          acc[lvl] = 1'b1;
        end else if (same != '0) begin
          node = same;
        end else begin
          dead = 1'b1;
        end
      end
    end
    return dead ? 32'h0 : acc;
  endfunction

  // Compare each result strobe first, then predict any item transferred on the same edge.
  always @(posedge clk) begin : watch
    answer_t want;
    logic    skip;
    if (rst) begin
      trie_clear();
      answers_due.delete();
      mismatches = 0;
      refused    = 0;
    end else begin
      if (done) begin
        if (answers_due.size() == 0) begin
          $error("result with no item outstanding: best_xor %h running_max %h",
                 best_xor, running_max);
          mismatches++;
        end else begin
          want = answers_due.pop_front();
          if (best_xor !== want.xr) begin
            $error("best_xor: expected %h, actual %h", want.xr, best_xor);
            mismatches++;
          end
          if (running_max !== want.peak) begin
            $error("running_max: expected %h, actual %h", want.peak, running_max);
            mismatches++;
          end
          if (pool_full !== want.full) begin
            $error("pool_full: expected %b, actual %b", want.full, pool_full);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        if (first_of_set) trie_clear();
        trie_insert(value, skip);
        want.xr = trie_best_xor(value);
        if (want.xr > peak_xor) peak_xor = want.xr;
        want.peak = peak_xor;
        want.full = skip;
        if (skip) refused++;
        answers_due.push_back(want);
      end
    end
    outstanding = answers_due.size();
  end

endmodule

@@ tb/sv/tb_binary_trie_max_xor_top.sv @@
// Testbench top: drives items into the binary trie maximum XOR block and gives the verdict.
module tb_binary_trie_max_xor_top;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 1000;
  localparam int IDLE_PCT     = 21;
  localparam int DRAIN_CYCLES = 80;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        start        = 1'b0;
  logic [31:0] value        = '0;
  logic        first_of_set = 1'b0;
  logic        busy;
  logic        done;
  logic [31:0] best_xor;
  logic [31:0] running_max;
  logic        pool_full;

  int          mismatches;
  int          outstanding;
  int          refused;
  int          cycles    = 0;
  int          items_out = 0;
  int          sets_out  = 0;
  bit          quiet     = 1'b0;
  logic [31:0] set_vals[$];

  binary_trie_max_xor_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .value       (value),
    .first_of_set(first_of_set),
    .done        (done),
    .best_xor    (best_xor),
    .running_max (running_max),
    .pool_full   (pool_full)
  );

  binary_trie_max_xor_checker i_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .value       (value),
    .first_of_set(first_of_set),
    .done        (done),
    .best_xor    (best_xor),
    .running_max (running_max),
    .pool_full   (pool_full),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .refused     (refused)
  );

  // Clock with a period of 8.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("binary_trie_max_xor_top verification failed");
      $finish;
    end
  end

  // Offer one item, idling in random cycles, until the block takes it.
  task automatic send_item(input logic [31:0] v, input logic f);
    bit taken;
    bit idle;
    taken = 1'b0;
    while (!taken) begin
      idle = !quiet && ($urandom_range(0, 99) < IDLE_PCT);
      if (idle) begin
        start        <= 1'b0;
        value        <= $urandom;
        first_of_set <= 1'($urandom_range(0, 1));
      end else begin
        start        <= 1'b1;
        value        <= v;
        first_of_set <= f;
      end
      @(posedge clk);
      taken = !idle && !busy;
    end
    items_out++;
    if (f) sets_out++;
  endtask

  // Pick a value for the current set; fill mode favors fresh paths to drain the pool.
  function automatic logic [31:0] pick_value(bit fill);
    int          kind;
    logic [31:0] base;
    kind = $urandom_range(0, 99);
    if ((fill && kind < 90) || set_vals.size() == 0 || kind < 40) return $urandom;
    base = set_vals[$urandom_range(0, set_vals.size() - 1)];
    if (kind < 55) return base;
    if (kind < 75) return base ^ ($urandom & ((32'h1 << $urandom_range(1, 12)) - 1));
    if (kind < 85) return {8'($urandom_range(0, 255)), 24'h0};
    if (kind < 90) return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    return base ^ (32'h1 << $urandom_range(0, 31));
  endfunction

  initial begin : stimulus
    int          sent;
    int          set_no;
    int          len;
    bit          long_set;
    logic [31:0] v;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed items: extremes, repeats of a stored value and set restarts.
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h0000_0000, 1'b1);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b1);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h5555_5555, 1'b1);
    send_item(32'hAAAA_AAAA, 1'b0);
    send_item(32'h1234_5678, 1'b1);
    send_item(32'h1234_5679, 1'b0);
    send_item(32'h1234_5678, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1);
    send_item(32'hFFFF_FFFF, 1'b1);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'h0000_0002, 1'b0);
    send_item(32'h0000_0004, 1'b0);
    send_item(32'h4000_0000, 1'b0);
    send_item(32'hDEAD_BEEF, 1'b1);

    // Random sets: mostly short, with some long enough to exhaust the node pool.
    sent   = 0;
    set_no = 0;
    while (sent < RANDOM_ITEMS) begin
      long_set = (set_no == 2) || ($urandom_range(0, 99) < 5);
      len      = long_set ? $urandom_range(420, 480) : $urandom_range(1, 24);
      set_vals.delete();
      for (int k = 0; k < len && sent < RANDOM_ITEMS; k++) begin
        v     = pick_value(long_set);
        quiet = (sent >= 200 && sent < 450);
        send_item(v, k == 0);
        set_vals.push_back(v);
        sent++;
      end
      set_no++;
    end
    start <= 1'b0;

    // Drain the outstanding results, then watch for stray strobes.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items in %0d sets; %0d inserts were refused on a full node pool.",
             items_out, sets_out, refused);
    if (mismatches == 0 && outstanding == 0) begin
      $display("binary_trie_max_xor_top verification clean");
    end else begin
      $display("binary_trie_max_xor_top verification failed");
    end
    $finish;
  end

endmodule
